// File: hdl/gisb_pkg.sv
// ----------------------------------------------------------------------------
// gisb_pkg: shared types, constants and functions
// Types and helpers shared by the matrix builder, the elimination cells and
// the output stage of the byte inversion core.
// ----------------------------------------------------------------------------
package gisb_pkg;

  // Field geometry: bytes are degree < 8 polynomials over GF(2).
  localparam int unsigned NumBits = 8;

  // Bit position of the right-hand side in an augmented row.
  localparam int unsigned RhsBit = NumBits;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegReductionPoly = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInverseOnly   = 2'd1;

  // Affine transform constants.
  localparam logic [NumBits-1:0] AffRow   = 8'hf1;
  localparam logic [NumBits-1:0] AffConst = 8'h63;

  // One augmented row: eight coefficient bits and the right-hand side.
  typedef logic [NumBits:0] row_t;

  // The augmented 8x9 linear system carried along the cell chain.
  typedef row_t [NumBits-1:0] mat_t;

  // Item handed from cell to cell: the system and a no-pivot flag.
  typedef struct packed {
    mat_t rows;
    logic singular;
  } gauss_t;

  // Standard AES affine map: bit j is the parity of x masked by the row
  // pattern rotated left by j, and the constant is added at the end.
  function automatic logic [NumBits-1:0] affine(input logic [NumBits-1:0] x);
    logic [NumBits-1:0]   res;
    logic [2*NumBits-1:0] wide;
    res = '0;
    for (int j = 0; j < NumBits; j++) begin
      wide   = {AffRow, AffRow} << j;
      res[j] = ^(wide[2*NumBits-1:NumBits] & x);
    end
    return res ^ AffConst;
  endfunction

endpackage

// File: hdl/gisb_matrix.sv
// ----------------------------------------------------------------------------
// gisb_matrix: multiplication matrix builder
// Builds the augmented system M_a * b = 1, where column k of M_a is
// a * x^k reduced modulo the reduction polynomial, and registers it.
// ----------------------------------------------------------------------------
module gisb_matrix (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [gisb_pkg::NumBits-1:0]    byte_i,
  input  logic [gisb_pkg::NumBits-1:0]    poly_low_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output gisb_pkg::gauss_t                data_o
);

  logic [gisb_pkg::NumBits-1:0] col [gisb_pkg::NumBits];
  gisb_pkg::gauss_t             data_d;
  gisb_pkg::gauss_t             data_q;
  logic                         valid_q;

  // Columns a * x^k: shift by one place and fold x^8 back each step.
  always_comb begin
    col[0] = byte_i;
    for (int k = 1; k < gisb_pkg::NumBits; k++) begin
      col[k] = {col[k-1][gisb_pkg::NumBits-2:0], 1'b0}
             ^ (col[k-1][gisb_pkg::NumBits-1] ? poly_low_i : '0);
    end
  end

  // Row i holds coefficient i of every column; the right side is 1 only
  // for the constant term.
  always_comb begin
    data_d.singular = 1'b0;
    for (int i = 0; i < gisb_pkg::NumBits; i++) begin
      for (int k = 0; k < gisb_pkg::NumBits; k++) begin
        data_d.rows[i][k] = col[k][i];
      end
      data_d.rows[i][gisb_pkg::RhsBit] = (i == 0);
    end
  end

  // Stage register: moves whenever it is empty or downstream takes it.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/gisb_cell.sv
// ----------------------------------------------------------------------------
// gisb_cell: one Gauss-Jordan elimination cell
// Clears one column of the system over GF(2): picks the first row at or
// below the diagonal with a one in that column, swaps it onto the
// diagonal and adds it to every other row that has a one there.
// ----------------------------------------------------------------------------
module gisb_cell #(
  parameter int unsigned Col = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  gisb_pkg::gauss_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output gisb_pkg::gauss_t data_o
);

  localparam int unsigned IdxW = $clog2(gisb_pkg::NumBits);
  localparam logic [IdxW-1:0] ColIdx = IdxW'(Col);

  logic             found;
  logic [IdxW-1:0]  piv;
  gisb_pkg::mat_t   swapped;
  gisb_pkg::gauss_t data_d;
  gisb_pkg::gauss_t data_q;
  logic             valid_q;

  // Pivot search among the rows not yet used as pivots.
  always_comb begin
    found = 1'b0;
    piv   = ColIdx;
    for (int r = 0; r < gisb_pkg::NumBits; r++) begin
      if (!found && (r >= Col) && data_i.rows[r][Col]) begin
        found = 1'b1;
        piv   = IdxW'(r);
      end
    end
  end

  // Swap the pivot row onto the diagonal, then eliminate the column.
  always_comb begin
    swapped      = data_i.rows;
    swapped[Col] = data_i.rows[piv];
    swapped[piv] = data_i.rows[Col];
    data_d.rows  = swapped;
    for (int i = 0; i < gisb_pkg::NumBits; i++) begin
      if (found && (i != Col) && swapped[i][Col]) begin
        data_d.rows[i] = swapped[i] ^ swapped[Col];
      end
    end
    data_d.singular = data_i.singular || !found;
  end

  // Stage register with bubble-collapsing flow control.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hdl/gisb_out.sv
// ----------------------------------------------------------------------------
// gisb_out: result stage
// Reads the inverse off the solved system, forces zero when no pivot was
// found, applies the affine map in S-box mode and holds the result item.
// ----------------------------------------------------------------------------
module gisb_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  gisb_pkg::gauss_t             data_i,
  input  logic                         inverse_only_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [gisb_pkg::NumBits-1:0] byte_o
);

  logic [gisb_pkg::NumBits-1:0] inv;
  logic [gisb_pkg::NumBits-1:0] byte_d;
  logic [gisb_pkg::NumBits-1:0] byte_q;
  logic                         valid_q;

  // After full elimination row k holds b_k on its right side.
  always_comb begin
    for (int k = 0; k < gisb_pkg::NumBits; k++) begin
      inv[k] = data_i.rows[k][gisb_pkg::RhsBit] && !data_i.singular;
    end
    byte_d = inverse_only_i ? inv : gisb_pkg::affine(inv);
  end

  // Output register: a waiting result does not block the chain behind it
  // while earlier stages still hold bubbles.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_d;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// File: hdl/gf256_inverse_sbox_core.sv
// ----------------------------------------------------------------------------
// gf256_inverse_sbox_core: GF(2^8) inverse and S-box substitution
// Inverts a byte modulo a programmable degree-8 polynomial by solving the
// linear system of its multiplication matrix in a chain of elimination
// cells, with the AES affine map as an option.
//
//   Channel  Direction  Handshake                 Payload
//   in       in         in_valid_i / in_ready_o   in_byte_i
//   out      out        out_valid_o / out_ready_i out_byte_o
//   cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_ready_i is high; the stages are the
// matrix builder, eight elimination cells (one per column) and the output
// register. Each stage advances when it is empty or the next stage takes
// its item, so a stalled output fills the chain before in_ready_o drops.
// Reset loads reduction_poly = 0x11B and inverse_only = 0 and empties the
// chain. Configuration writes are always taken; out-of-range indexes are
// dropped.
// ----------------------------------------------------------------------------
module gf256_inverse_sbox_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          in_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          out_byte_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gisb_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [8:0]                          cfg_data_i
);

  localparam int unsigned NumStages = gisb_pkg::NumBits + 1;

  logic [8:0]       reduction_poly_q;
  logic             inverse_only_q;
  logic             st_valid [NumStages];
  logic             st_ready [NumStages];
  gisb_pkg::gauss_t st_data  [NumStages];

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduction_poly_q <= 9'h11b;
      inverse_only_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gisb_pkg::RegReductionPoly: reduction_poly_q <= cfg_data_i;
        gisb_pkg::RegInverseOnly:   inverse_only_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Matrix builder; bit 8 of the polynomial is always taken as set.
  gisb_matrix u_matrix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .byte_i     (in_byte_i),
    .poly_low_i (reduction_poly_q[7:0]),
    .valid_o    (st_valid[0]),
    .ready_i    (st_ready[0]),
    .data_o     (st_data[0])
  );

  // Elimination chain, one cell per column.
  for (genvar c = 0; c < gisb_pkg::NumBits; c++) begin : g_cell
    gisb_cell #(
      .Col (c)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[c]),
      .ready_o (st_ready[c]),
      .data_i  (st_data[c]),
      .valid_o (st_valid[c+1]),
      .ready_i (st_ready[c+1]),
      .data_o  (st_data[c+1])
    );
  end

  // Result stage.
  gisb_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (st_valid[NumStages-1]),
    .ready_o        (st_ready[NumStages-1]),
    .data_i         (st_data[NumStages-1]),
    .inverse_only_i (inverse_only_q),
    .valid_o        (out_valid_o),
    .ready_i        (out_ready_i),
    .byte_o         (out_byte_o)
  );

endmodule
